FILE: hw/rtl/mbpe_pkg.sv
// mbpe_pkg: shared types and constants of the monochrome byte pixel expander
// used by the front, queue, back, top level and bench; no dependencies
`timescale 1ns / 1ps

package mbpe_pkg;

  // draw mode codes
  localparam logic [1:0] MODE_OPAQUE      = 2'd0;
  localparam logic [1:0] MODE_TRANSPARENT = 2'd1;
  localparam logic [1:0] MODE_INVERT      = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_DRAW_MODE  = 2'd0;
  localparam logic [1:0] CFG_FORE_COLOR = 2'd1;
  localparam logic [1:0] CFG_BACK_COLOR = 2'd2;

  // register reset values
  localparam logic [31:0] FORE_COLOR_RST = 32'hFFFF_FFFF;
  localparam logic [31:0] BACK_COLOR_RST = 32'hFF00_0000;

  // pixel operation codes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_INVERT = 1'b1;

  // pixels per pattern byte and queue depth
  localparam int unsigned PIX_PER_ITEM = 8;
  localparam int unsigned QUEUE_DEPTH  = 2;

  // one classified item waiting for the back end
  typedef struct packed {
    logic [7:0]  keep;      // pixel i survives the drawing rules
    logic [7:0]  bits;      // pattern bit of pixel i, already reordered
    logic        vertical;  // pixels step down a column
    logic        invert;    // emit invert operations
    logic [31:0] fore;
    logic [31:0] back;
    logic [16:0] base;      // frame index of pixel 0, modulo 2^17
  } job_t;

endpackage

FILE: hw/rtl/mbpe_in_if.sv
// mbpe_in_if: input channel, one pattern byte with start coordinate per item
// depends on nothing
`timescale 1ns / 1ps

interface mbpe_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [7:0]         pattern;
  logic signed [11:0] x_start;
  logic signed [11:0] y_start;

  modport source (output valid, func, pattern, x_start, y_start, input ready);
  modport sink   (input valid, func, pattern, x_start, y_start, output ready);
endinterface

FILE: hw/rtl/mbpe_out_if.sv
// mbpe_out_if: result channel, one frame-store operation per item
// depends on nothing
`timescale 1ns / 1ps

interface mbpe_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] pixel_index;
  logic [31:0] pixel_color;
  logic        pixel_op;
  logic        last_pixel;

  modport source (output valid, pixel_index, pixel_color, pixel_op, last_pixel,
                  input ready);
  modport sink   (input valid, pixel_index, pixel_color, pixel_op, last_pixel,
                  output ready);
endinterface

FILE: hw/rtl/mbpe_front.sv
// mbpe_front: configuration registers, item accept and per-pixel classification
// depends on mbpe_pkg and mbpe_in_if
`timescale 1ns / 1ps

module mbpe_front
  import mbpe_pkg::*;
#(
  parameter int FB_WIDTH  = 240,
  parameter int FB_HEIGHT = 320
) (
  input  logic        clk,
  input  logic        rst_n,
  mbpe_in_if.sink     in_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output logic        push,
  output job_t        push_job,
  input  logic        q_ready
);

  localparam logic signed [12:0] W_S = 13'(FB_WIDTH);
  localparam logic signed [12:0] H_S = 13'(FB_HEIGHT);

  logic [1:0]  mode_r;
  logic [31:0] fore_r;
  logic [31:0] back_r;

  logic signed [12:0] x0;
  logic signed [12:0] y0;
  logic signed [12:0] px   [PIX_PER_ITEM];
  logic signed [12:0] py   [PIX_PER_ITEM];
  logic [7:0]         bits;
  logic [7:0]         keep;
  logic signed [24:0] base_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_OPAQUE;
      fore_r <= FORE_COLOR_RST;
      back_r <= BACK_COLOR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DRAW_MODE:  mode_r <= cfg_wdata[1:0];
        CFG_FORE_COLOR: fore_r <= cfg_wdata;
        CFG_BACK_COLOR: back_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pixel coordinates and survival mask
  always_comb begin
    x0 = {in_ch.x_start[11], in_ch.x_start};
    y0 = {in_ch.y_start[11], in_ch.y_start};
    for (int i = 0; i < PIX_PER_ITEM; i++) begin
      px[i]   = in_ch.func ? x0 : x0 + 13'(i);
      py[i]   = in_ch.func ? y0 + 13'(i) : y0;
      bits[i] = in_ch.func ? in_ch.pattern[i] : in_ch.pattern[3'(7 - i)];
      case (mode_r)
        MODE_OPAQUE:      keep[i] = 1'b1;
        MODE_TRANSPARENT: keep[i] = bits[i];
        MODE_INVERT:      keep[i] = bits[i];
        default:          keep[i] = 1'b0;
      endcase
      if (px[i] < 0 || px[i] >= W_S || py[i] < 0 || py[i] >= H_S)
        keep[i] = 1'b0;
    end
  end

  // frame index of pixel 0, wraps modulo the index width
  assign base_full = 25'(y0) * 25'(W_S) + 25'(x0);

  // items with no surviving pixel are taken but not queued
  assign in_ch.ready = q_ready;
  assign push        = in_ch.valid && q_ready && (keep != 8'd0);

  always_comb begin
    push_job.keep     = keep;
    push_job.bits     = bits;
    push_job.vertical = in_ch.func;
    push_job.invert   = (mode_r == MODE_INVERT);
    push_job.fore     = fore_r;
    push_job.back     = back_r;
    push_job.base     = base_full[16:0];
  end

endmodule

FILE: hw/rtl/mbpe_queue.sv
// mbpe_queue: short queue of classified items between front and back
// depends on mbpe_pkg
`timescale 1ns / 1ps

module mbpe_queue
  import mbpe_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic q_ready,
  output logic q_valid,
  output job_t q_job,
  input  logic pop
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign q_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_job   = slot_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // item storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_job;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> q_ready) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid) else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");
`endif

endmodule

FILE: hw/rtl/mbpe_back.sv
// mbpe_back: walks the surviving pixels of one item, one operation per cycle
// while the receiver is ready; depends on mbpe_pkg and mbpe_out_if
`timescale 1ns / 1ps

module mbpe_back
  import mbpe_pkg::*;
#(
  parameter int FB_WIDTH = 240
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_valid,
  input  job_t     q_job,
  output logic     pop,
  mbpe_out_if.source out_ch
);

  localparam logic [16:0] STRIDE_V = 17'(FB_WIDTH);

  job_t        cur_r, cur_nxt;
  logic        cur_valid_r, cur_valid_nxt;
  logic        out_valid_r;
  logic [16:0] index_r;
  logic [31:0] color_r;
  logic        op_r;
  logic        last_r;

  logic [2:0]  idx;
  logic [7:0]  rest;
  logic        last;
  logic        emit;
  logic [16:0] offset;

  // lowest surviving pixel of the current item
  always_comb begin
    idx = '0;
    for (int i = PIX_PER_ITEM - 1; i >= 0; i--) begin
      if (cur_r.keep[i]) idx = 3'(i);
    end
  end

  assign rest   = cur_r.keep & ~(8'd1 << idx);
  assign last   = (rest == 8'd0);
  assign emit   = cur_valid_r && (!out_valid_r || out_ch.ready);
  assign pop    = q_valid && (!cur_valid_r || (emit && last));
  assign offset = cur_r.vertical ? 17'(idx) * STRIDE_V : 17'(idx);

  // current item sequencing
  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    if (pop) begin
      cur_nxt       = q_job;
      cur_valid_nxt = 1'b1;
    end else if (emit) begin
      cur_nxt.keep  = rest;
      cur_valid_nxt = !last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      if (emit) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (emit) begin
      index_r <= cur_r.base + offset;
      last_r  <= last;
      if (cur_r.invert) begin
        color_r <= 32'd0;
        op_r    <= OP_INVERT;
      end else begin
        color_r <= cur_r.bits[idx] ? cur_r.fore : cur_r.back;
        op_r    <= OP_WRITE;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pixel_index = index_r;
  assign out_ch.pixel_color = color_r;
  assign out_ch.pixel_op    = op_r;
  assign out_ch.last_pixel  = last_r;

`ifndef SYNTHESIS
  a_cur_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (cur_r.keep != 8'd0)) else $error("active item has no pixels");
  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r) else $error("emitted operation not presented");
  a_pop_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && cur_valid_r) |-> (emit && last)) else $error("item replaced early");
`endif

endmodule

FILE: hw/rtl/mono_byte_pixel_expander.sv
// mono_byte_pixel_expander: an item passes the queue slot, the current item and
// output registers before its first result. the back end issues one operation
// per surviving pixel, one per cycle while the receiver is ready; the front takes
// an item per cycle while the two-entry queue has room, not queuing empty items.
// reset (synchronous, rst_n low) empties queue and output and restores
// draw_mode opaque, fore_color 0xFFFFFFFF, back_color 0xFF000000
`timescale 1ns / 1ps

module mono_byte_pixel_expander
  import mbpe_pkg::*;
#(
  parameter int FB_WIDTH  = 240,
  parameter int FB_HEIGHT = 320
) (
  input  logic        clk,
  input  logic        rst_n,
  mbpe_in_if.sink     in_ch,
  mbpe_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  logic push;
  job_t push_job;
  logic q_ready;
  logic q_valid;
  job_t q_job;
  logic pop;

  // accept and classify
  mbpe_front #(
    .FB_WIDTH  (FB_WIDTH),
    .FB_HEIGHT (FB_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .push_job  (push_job),
    .q_ready   (q_ready)
  );

  // decoupling queue
  mbpe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .q_ready  (q_ready),
    .q_valid  (q_valid),
    .q_job    (q_job),
    .pop      (pop)
  );

  // pixel sequencer and output register
  mbpe_back #(
    .FB_WIDTH (FB_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_job   (q_job),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

FILE: test/tb_top.sv
// tb_top: self-checking bench for mono_byte_pixel_expander, directed and random items
// depends on mbpe_pkg, mbpe_in_if, mbpe_out_if and the mono_byte_pixel_expander rtl
`timescale 1ns / 1ps

module tb_top
  import mbpe_pkg::*;
();

  localparam int FB_W = 240;
  localparam int FB_H = 320;
  localparam int SETTLE_CYCLES = 24;
  localparam int ITEMS_PER_PHASE = 26;
  localparam int RANDOM_PHASES = 8;
  localparam int MAX_PRINTED = 30;

  // draw mode code that draws nothing, and a register index the block ignores
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  // one input item: pattern byte, direction and start coordinate
  typedef struct packed {
    logic               func;
    logic [7:0]         pattern;
    logic signed [11:0] x_start;
    logic signed [11:0] y_start;
  } blit_req_t;

  // one frame-store operation
  typedef struct packed {
    logic [16:0] index;
    logic [31:0] color;
    logic        pix_op;
    logic        pix_last;
  } pix_write_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  mbpe_in_if  in_bus ();
  mbpe_out_if out_bus ();

  // bench copy of the configuration registers
  logic [1:0]  mode_now = MODE_OPAQUE;
  logic [31:0] fore_now = FORE_COLOR_RST;
  logic [31:0] back_now = BACK_COLOR_RST;

  pix_write_t pending_writes[$];
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         mismatches = 0;

  mono_byte_pixel_expander #(
    .FB_WIDTH  (FB_W),
    .FB_HEIGHT (FB_H)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("mono_byte_pixel_expander verification failed");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("ERROR at %0t ns: %s", $time, what);
  endtask

  // frame-store operations that one item causes under the current registers
  function automatic void expand_pattern(input blit_req_t req);
    pix_write_t ops[$];
    pix_write_t op;
    int col;
    int row;
    logic lit;
    if (mode_now > MODE_INVERT) return;
    for (int i = 0; i < PIX_PER_ITEM; i++) begin
      col = $signed(req.x_start);
      row = $signed(req.y_start);
      // vertical walks down from bit 0, horizontal walks right from bit 7
      if (req.func) begin
        lit = req.pattern[i];
        row += i;
      end else begin
        lit = req.pattern[7 - i];
        col += i;
      end
      op.pix_op = OP_WRITE;
      op.pix_last = 1'b0;
      if (mode_now == MODE_OPAQUE) op.color = lit ? fore_now : back_now;
      else if (!lit) continue;
      else if (mode_now == MODE_TRANSPARENT) op.color = fore_now;
      else begin
        op.color = '0;
        op.pix_op = OP_INVERT;
      end
      // off-screen pixels are dropped
      if (col < 0 || col >= FB_W || row < 0 || row >= FB_H) continue;
      op.index = 17'(row * FB_W + col);
      ops.push_back(op);
    end
    if (ops.size() > 0) ops[ops.size() - 1].pix_last = 1'b1;
    foreach (ops[k]) pending_writes.push_back(ops[k]);
  endfunction

  function automatic blit_req_t make_req(input logic func, input logic [7:0] pattern,
                                         input int x, input int y);
    blit_req_t req;
    req.func = func;
    req.pattern = pattern;
    req.x_start = 12'(x);
    req.y_start = 12'(y);
    return req;
  endfunction

  // mostly on screen, some around the edges, some anywhere in the 12-bit range
  function automatic logic signed [11:0] pick_coord(input int span);
    case ($urandom_range(9))
      0: return 12'($urandom);
      1: return 12'($urandom_range(9) - 9);
      2: return 12'(span - 8 + $urandom_range(9));
      default: return 12'($urandom_range(span - 1));
    endcase
  endfunction

  function automatic logic [31:0] pick_color();
    case ($urandom_range(3))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return 32'($urandom);
    endcase
  endfunction

  function automatic blit_req_t random_req();
    blit_req_t req;
    req.func = 1'($urandom_range(1));
    case ($urandom_range(7))
      0: req.pattern = 8'h00;
      1: req.pattern = 8'hFF;
      default: req.pattern = 8'($urandom);
    endcase
    req.x_start = pick_coord(FB_W);
    req.y_start = pick_coord(FB_H);
    return req;
  endfunction

  // drive one item from a falling edge and wait for its handshake
  task automatic send_item(input blit_req_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.func <= req.func;
    in_bus.pattern <= req.pattern;
    in_bus.x_start <= req.x_start;
    in_bus.y_start <= req.y_start;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    expand_pattern(req);
    @(negedge clk);
  endtask

  // wait until every expected operation is out and the block has gone quiet
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (pending_writes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // write all three registers, optionally followed by a write to the unused index
  task automatic write_regs(input logic [1:0] mode, input logic [31:0] fore,
                            input logic [31:0] back, input bit poke_unused);
    cfg_we <= 1'b1;
    cfg_index <= CFG_DRAW_MODE;
    cfg_wdata <= {30'($urandom), mode};
    @(negedge clk);
    cfg_index <= CFG_FORE_COLOR;
    cfg_wdata <= fore;
    @(negedge clk);
    cfg_index <= CFG_BACK_COLOR;
    cfg_wdata <= back;
    @(negedge clk);
    if (poke_unused) begin
      cfg_index <= CFG_UNUSED;
      cfg_wdata <= $urandom;
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    mode_now = mode;
    fore_now = fore;
    back_now = back;
    @(negedge clk);
  endtask

  // receiver: ready changes at the falling edge
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(negedge clk);
      out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // compare each accepted operation with the oldest expected one
  always @(posedge clk) begin : check_writes
    pix_write_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_writes.size() == 0) begin
        report_mismatch($sformatf("unexpected operation at index %0d", out_bus.pixel_index));
      end else begin
        want = pending_writes.pop_front();
        if (out_bus.pixel_index !== want.index)
          report_mismatch($sformatf("pixel_index %0d, want %0d",
                                    out_bus.pixel_index, want.index));
        if (out_bus.pixel_color !== want.color)
          report_mismatch($sformatf("pixel_color %h, want %h at index %0d",
                                    out_bus.pixel_color, want.color, want.index));
        if (out_bus.pixel_op !== want.pix_op)
          report_mismatch($sformatf("pixel_op %b, want %b at index %0d",
                                    out_bus.pixel_op, want.pix_op, want.index));
        if (out_bus.last_pixel !== want.pix_last)
          report_mismatch($sformatf("last_pixel %b, want %b at index %0d",
                                    out_bus.last_pixel, want.pix_last, want.index));
      end
    end
  end

  // opaque drawing with the reset colors, clipping on every side
  task automatic test_reset_defaults();
    send_item(make_req(1'b0, 8'hA5, 0, 0));
    send_item(make_req(1'b1, 8'h3C, 239, 319));
    send_item(make_req(1'b0, 8'hFF, 232, 319));
    send_item(make_req(1'b0, 8'h81, 236, 5));
    send_item(make_req(1'b1, 8'h81, 5, -3));
    send_item(make_req(1'b0, 8'h00, -2048, -2048));
    send_item(make_req(1'b1, 8'hFF, 2047, 2047));
    send_item(make_req(1'b0, 8'h5A, -8, 10));
    send_item(make_req(1'b0, 8'h96, -4, 100));
  endtask

  // transparent mode only writes set bits
  task automatic test_transparent();
    drain();
    write_regs(MODE_TRANSPARENT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    send_item(make_req(1'b0, 8'h00, 10, 10));
    send_item(make_req(1'b0, 8'h80, 0, 0));
    send_item(make_req(1'b1, 8'h01, 0, 319));
    send_item(make_req(1'b0, 8'h01, 232, 0));
    send_item(make_req(1'b1, 8'hFF, 120, 315));
  endtask

  // invert mode emits invert operations with zero color
  task automatic test_invert();
    drain();
    write_regs(MODE_INVERT, 32'($urandom), 32'($urandom), 1'b0);
    send_item(make_req(1'b0, 8'h80, 239, 0));
    send_item(make_req(1'b1, 8'h80, 0, 312));
    send_item(make_req(1'b0, 8'hFF, -1, 319));
    send_item(make_req(1'b1, 8'h00, 5, 5));
    send_item(make_req(1'b0, 8'h5A, 100, -1));
  endtask

  // unused mode code draws nothing
  task automatic test_unused_mode();
    drain();
    write_regs(MODE_UNUSED, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    send_item(make_req(1'b0, 8'hFF, 0, 0));
    send_item(make_req(1'b1, 8'h00, 10, 10));
  endtask

  // a write to an unknown index leaves the registers alone
  task automatic test_unknown_index();
    drain();
    write_regs(MODE_OPAQUE, 32'($urandom), 32'($urandom), 1'b1);
    send_item(make_req(1'b0, 8'hC3, 50, 60));
    send_item(make_req(1'b1, 8'h3C, 60, 50));
  endtask

  // random items over several register settings and idling profiles
  task automatic test_random_traffic();
    logic [1:0] mode;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain();
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 88;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 88;
        end
        default: begin
          send_idle_pct = 27;
          recv_stall_pct = 27;
        end
      endcase
      case (phase % 3)
        0: mode = MODE_OPAQUE;
        1: mode = MODE_TRANSPARENT;
        default: mode = MODE_INVERT;
      endcase
      write_regs(mode, pick_color(), pick_color(), phase[0]);
      repeat (ITEMS_PER_PHASE) send_item(random_req());
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_DRAW_MODE;
    cfg_wdata <= '0;
    in_bus.valid <= 1'b0;
    in_bus.func <= 1'b0;
    in_bus.pattern <= '0;
    in_bus.x_start <= '0;
    in_bus.y_start <= '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_transparent();
    test_invert();
    test_unused_mode();
    test_unknown_index();
    test_random_traffic();
    drain();

    if (mismatches == 0) begin
      $display("mono_byte_pixel_expander verification clean");
    end else begin
      $display("mono_byte_pixel_expander verification failed");
    end
    $finish;
  end

endmodule
